>>> src/mdc_pkg.sv
`default_nettype none

package mdc_pkg;

    // Channel and field geometry.
    localparam int MOTOR_COUNT    = 2;
    localparam int MOTOR_IDX_W    = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int CFG_MOTORS     = 2;
    localparam int SPEED_W        = 16;
    localparam int TIME_W         = 32;
    localparam int LEVEL_W        = 15;
    localparam int GAIN_W         = 16;
    localparam int BOOST_W        = 32;
    localparam int BOOST_LVL_W    = 16;
    localparam int BOOST_MS_W     = 16;

    // Gain arithmetic.
    localparam int GAIN_FRAC_BITS = 12;
    localparam int PROD_W         = SPEED_W + GAIN_W + 1;
    localparam int MAG_W          = PROD_W - GAIN_FRAC_BITS;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC_BITS);

    // Configuration port.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [LEVEL_W-1:0] EPSILON_RESET = LEVEL_W'(5);
    localparam logic [LEVEL_W-1:0] LIMIT_RESET   = LEVEL_W'(32767);

    typedef enum logic [2:0] {
        REG_TARGET_EPSILON = 3'd0,
        REG_DRIVE_LIMIT    = 3'd1,
        REG_GAIN_MOTOR0    = 3'd2,
        REG_GAIN_MOTOR1    = 3'd3,
        REG_MIN_MOTOR0     = 3'd4,
        REG_MIN_MOTOR1     = 3'd5,
        REG_BOOST_MOTOR0   = 3'd6,
        REG_BOOST_MOTOR1   = 3'd7
    } mdc_reg_idx_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]                    target_epsilon;
        logic [LEVEL_W-1:0]                    drive_limit;
        logic [CFG_MOTORS-1:0][GAIN_W-1:0]     gain;
        logic [CFG_MOTORS-1:0][LEVEL_W-1:0]    min_drive;
        logic [CFG_MOTORS-1:0][BOOST_W-1:0]    boost;
    } mdc_cfg_t;

    // Magnitude of a signed speed, one bit wider so that -32768 fits.
    function automatic logic [SPEED_W:0] abs_speed(input logic signed [SPEED_W-1:0] v);
        logic [SPEED_W:0] ext;
        ext = {v[SPEED_W-1], v};
        return v[SPEED_W-1] ? (~ext + (SPEED_W+1)'(1)) : ext;
    endfunction

endpackage

`default_nettype wire

>>> src/mdc_sample_if.sv
`default_nettype none

interface mdc_sample_if;
    logic                                valid;
    logic                                ready;
    logic                                motor_select;
    logic signed [mdc_pkg::SPEED_W-1:0]  speed_cmd;
    logic signed [mdc_pkg::SPEED_W-1:0]  measured_speed;
    logic signed [mdc_pkg::SPEED_W-1:0]  pid_drive;
    logic        [mdc_pkg::TIME_W-1:0]   now_ms;

    modport source (
        output valid, motor_select, speed_cmd, measured_speed, pid_drive, now_ms,
        input  ready
    );

    modport sink (
        input  valid, motor_select, speed_cmd, measured_speed, pid_drive, now_ms,
        output ready
    );
endinterface

`default_nettype wire

>>> src/mdc_result_if.sv
`default_nettype none

interface mdc_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [mdc_pkg::SPEED_W-1:0]  drive_out;

    modport source (
        output valid, drive_out,
        input  ready
    );

    modport sink (
        input  valid, drive_out,
        output ready
    );
endinterface

`default_nettype wire

>>> src/mdc_cfg_regs.sv
`default_nettype none

module mdc_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mdc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [mdc_pkg::PDATA_W-1:0]   pwdata,
    output logic      [mdc_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    output mdc_pkg::mdc_cfg_t                  cfg
);
    import mdc_pkg::*;

    mdc_cfg_t     cfg_reg;
    mdc_cfg_t     cfg_next;
    mdc_reg_idx_t reg_idx;
    logic         wr_en;

    assign pready  = 1'b1;
    assign reg_idx = mdc_reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_TARGET_EPSILON: cfg_next.target_epsilon = pwdata[LEVEL_W-1:0];
                REG_DRIVE_LIMIT:    cfg_next.drive_limit    = pwdata[LEVEL_W-1:0];
                REG_GAIN_MOTOR0:    cfg_next.gain[0]        = pwdata[GAIN_W-1:0];
                REG_GAIN_MOTOR1:    cfg_next.gain[1]        = pwdata[GAIN_W-1:0];
                REG_MIN_MOTOR0:     cfg_next.min_drive[0]   = pwdata[LEVEL_W-1:0];
                REG_MIN_MOTOR1:     cfg_next.min_drive[1]   = pwdata[LEVEL_W-1:0];
                REG_BOOST_MOTOR0:   cfg_next.boost[0]       = pwdata[BOOST_W-1:0];
                REG_BOOST_MOTOR1:   cfg_next.boost[1]       = pwdata[BOOST_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TARGET_EPSILON: prdata = PDATA_W'(cfg_reg.target_epsilon);
            REG_DRIVE_LIMIT:    prdata = PDATA_W'(cfg_reg.drive_limit);
            REG_GAIN_MOTOR0:    prdata = PDATA_W'(cfg_reg.gain[0]);
            REG_GAIN_MOTOR1:    prdata = PDATA_W'(cfg_reg.gain[1]);
            REG_MIN_MOTOR0:     prdata = PDATA_W'(cfg_reg.min_drive[0]);
            REG_MIN_MOTOR1:     prdata = PDATA_W'(cfg_reg.min_drive[1]);
            REG_BOOST_MOTOR0:   prdata = PDATA_W'(cfg_reg.boost[0]);
            REG_BOOST_MOTOR1:   prdata = PDATA_W'(cfg_reg.boost[1]);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_epsilon <= EPSILON_RESET;
            cfg_reg.drive_limit    <= LIMIT_RESET;
            for (int i = 0; i < CFG_MOTORS; i++)
            begin
                cfg_reg.gain[i]      <= GAIN_ONE;
                cfg_reg.min_drive[i] <= '0;
                cfg_reg.boost[i]     <= '0;
            end
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> src/mdc_core.sv
`default_nettype none

module mdc_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mdc_pkg::mdc_cfg_t cfg,
    mdc_sample_if.sink             sample,
    mdc_result_if.source           result
);
    import mdc_pkg::*;

    // Input register.
    logic                      s1_valid_reg;
    logic                      s1_sel_reg;
    logic signed [SPEED_W-1:0] s1_target_reg;
    logic signed [SPEED_W-1:0] s1_measured_reg;
    logic signed [SPEED_W-1:0] s1_pid_reg;
    logic [TIME_W-1:0]         s1_now_reg;

    // Result register.
    logic                      out_valid_reg;
    logic signed [SPEED_W-1:0] drive_out_reg;
    logic signed [SPEED_W-1:0] drive_out_next;

    // Per-motor state.
    logic signed [SPEED_W-1:0] prev_target_reg [MOTOR_COUNT];
    logic [TIME_W-1:0]         deadline_reg    [MOTOR_COUNT];
    logic signed [SPEED_W-1:0] prev_target_next;
    logic [TIME_W-1:0]         deadline_next;

    logic                      advance;
    logic                      take_in;
    logic [MOTOR_IDX_W-1:0]    m_idx;
    logic                      c_idx;

    logic [GAIN_W-1:0]         gain_eff;
    logic [LEVEL_W-1:0]        min_lvl;
    logic [BOOST_LVL_W-1:0]    boost_lvl;
    logic [BOOST_MS_W-1:0]     boost_ms;

    logic [SPEED_W:0]          t_abs;
    logic [SPEED_W:0]          m_abs;
    logic [SPEED_W:0]          last_abs;
    logic signed [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]         prod_abs;
    logic [PROD_W:0]           prod_rnd;
    logic [MAG_W-1:0]          mag0;
    logic [MAG_W-1:0]          mag1;
    logic [MAG_W-1:0]          mag2;
    logic [MAG_W-1:0]          mag3;
    logic                      neg0;
    logic                      neg1;
    logic                      neg2;
    logic [SPEED_W-1:0]        mag_out;

    logic                      stop;
    logic                      from_rest;
    logic                      reversed;
    logic                      arm;
    logic [TIME_W-1:0]         deadline_eff;
    logic                      same_dir;
    logic                      lagging;
    logic                      do_boost;
    logic                      do_min;

    assign advance      = !out_valid_reg || result.ready;
    assign sample.ready = !s1_valid_reg || advance;
    assign take_in      = sample.valid && sample.ready;

    assign result.valid     = out_valid_reg;
    assign result.drive_out = drive_out_reg;

    always_comb
    begin
        if (int'(s1_sel_reg) >= MOTOR_COUNT)
            m_idx = MOTOR_IDX_W'(MOTOR_COUNT - 1);
        else
            m_idx = MOTOR_IDX_W'(s1_sel_reg);
    end

    // The register file holds two motors' worth of settings; the low index bit picks one.
    assign c_idx     = m_idx[0];
    assign gain_eff  = (cfg.gain[c_idx] == '0) ? GAIN_ONE : cfg.gain[c_idx];
    assign min_lvl   = cfg.min_drive[c_idx];
    assign boost_lvl = cfg.boost[c_idx][BOOST_LVL_W-1:0];
    assign boost_ms  = cfg.boost[c_idx][BOOST_W-1:BOOST_LVL_W];

    assign t_abs    = abs_speed(s1_target_reg);
    assign m_abs    = abs_speed(s1_measured_reg);
    assign last_abs = abs_speed(prev_target_reg[m_idx]);

    assign stop        = t_abs <= (SPEED_W+1)'(cfg.target_epsilon);
    assign from_rest   = last_abs <= (SPEED_W+1)'(cfg.target_epsilon);
    assign reversed    = (prev_target_reg[m_idx] != '0)
                         && (prev_target_reg[m_idx][SPEED_W-1] != s1_target_reg[SPEED_W-1]);
    assign arm         = (from_rest || reversed) && (boost_lvl != '0) && (boost_ms != '0);
    assign deadline_eff = arm ? (s1_now_reg + TIME_W'(boost_ms)) : deadline_reg[m_idx];

    // Gain scaling, rounded half away from zero on the magnitude.
    assign prod     = PROD_W'(s1_pid_reg) * $signed({1'b0, gain_eff});
    assign prod_abs = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    assign prod_rnd = {1'b0, prod_abs} + (PROD_W+1)'(1 << (GAIN_FRAC_BITS - 1));
    assign mag0     = prod_rnd[GAIN_FRAC_BITS +: MAG_W];
    assign neg0     = prod[PROD_W-1] && (mag0 != '0);

    assign same_dir = (mag0 == '0) || (neg0 == s1_target_reg[SPEED_W-1]);
    assign lagging  = ({1'b0, m_abs} + (SPEED_W+2)'(cfg.target_epsilon)) < {1'b0, t_abs};
    assign do_boost = (boost_lvl != '0) && (s1_now_reg < deadline_eff) && same_dir && lagging;
    assign do_min   = (min_lvl != '0) && same_dir && lagging;

    always_comb
    begin
        // Boost level first, then the minimum level, both pointing the target's way.
        mag1 = mag0;
        neg1 = neg0;
        if (do_boost && (mag0 < MAG_W'(boost_lvl)))
        begin
            mag1 = MAG_W'(boost_lvl);
            neg1 = s1_target_reg[SPEED_W-1];
        end
        mag2 = mag1;
        neg2 = neg1;
        if (do_min && (mag1 < MAG_W'(min_lvl)))
        begin
            mag2 = MAG_W'(min_lvl);
            neg2 = s1_target_reg[SPEED_W-1];
        end
        mag3 = (mag2 > MAG_W'(cfg.drive_limit)) ? MAG_W'(cfg.drive_limit) : mag2;
        mag_out = mag3[SPEED_W-1:0];

        if (stop)
        begin
            drive_out_next   = '0;
            prev_target_next = '0;
            deadline_next    = '0;
        end
        else
        begin
            drive_out_next   = neg2 ? $signed(-mag_out) : $signed(mag_out);
            prev_target_next = s1_target_reg;
            deadline_next    = deadline_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MOTOR_COUNT; i++)
            begin
                prev_target_reg[i] <= '0;
                deadline_reg[i]    <= '0;
            end
        end
        else
        begin
            if (sample.ready)
                s1_valid_reg <= sample.valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
            if (advance && s1_valid_reg)
            begin
                prev_target_reg[m_idx] <= prev_target_next;
                deadline_reg[m_idx]    <= deadline_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_sel_reg      <= sample.motor_select;
            s1_target_reg   <= sample.speed_cmd;
            s1_measured_reg <= sample.measured_speed;
            s1_pid_reg      <= sample.pid_drive;
            s1_now_reg      <= sample.now_ms;
        end
        if (advance && s1_valid_reg)
            drive_out_reg <= drive_out_next;
    end

endmodule

`default_nettype wire

>>> src/motor_drive_compensation.sv
// Motor drive compensation: dead-band handling and a start-up kick for two motors.
// Requests arrive on the sample channel (valid/ready) carrying the motor index,
// target and measured speed, the raw controller drive and a millisecond time stamp.
// Each request produces exactly one response on the result channel: the compensated,
// saturated drive. A request is accepted into an input register; the first clock
// edge at which the result register is free computes the drive, updates that motor's
// state and loads the result register, which then presents the response.
// With result.ready high the block accepts one request every cycle, as the input
// register refills at the same edge at which the result register loads; the gain
// multiplier and the compares between the two registers set only the clock period.
// Requests for the same motor may follow back to back, since the state update lands
// in the same edge that consumes the previous request. When the receiver holds ready
// low, the result register keeps its value and the input register can still take one
// more request before ready drops. Reset clears both motors' previous target and
// boost deadline and loads the configuration defaults. The user must write
// configuration through the APB port while idle; the block does not enforce this.
`default_nettype none

module motor_drive_compensation (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mdc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [mdc_pkg::PDATA_W-1:0]   pwdata,
    output logic      [mdc_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    mdc_sample_if.sink                         sample,
    mdc_result_if.source                       result
);
    import mdc_pkg::*;

    // Live configuration shared with the datapath.
    mdc_cfg_t cfg;

    mdc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register, compensation logic, per-motor state and result register.
    mdc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .sample (sample),
        .result (result)
    );

endmodule

`default_nettype wire

>>> bench/motor_drive_compensation_tb.sv
`default_nettype none

// Self-checking bench for the motor drive compensation block.
//
// The bench holds its own model of the block: a shadow copy of the eight
// registers and, per motor, the last target and the kick deadline. Every
// request that the block accepts is run through that model at the edge of
// acceptance, and the predicted drive is queued. The result channel is watched
// on every edge, and each accepted result is compared with the oldest queued
// prediction.
//
// Stimulus comes in two parts. A short plan of hand-written requests and
// register writes walks through the stopping threshold, the gain extremes, the
// rounding of halves, saturation, the minimum drive, the kick window and the
// kick deadline that wraps past the top of the millisecond counter. Where the
// answer is obvious the plan carries it and the bench checks against that value
// directly. After that come eight register settings (defaults, two sets of
// extremes, then random ones), each followed by a burst of random requests that
// mimic a control loop: targets that hold, stop, reverse or jump, measured
// speeds that lag, and a millisecond clock that creeps forward.
module motor_drive_compensation_tb;

    import mdc_pkg::*;

    // Cycles in a row with no request and no result accepted before the run is
    // declared hung. Even a very unlucky run of receiver stalls stays far below.
    localparam int STALL_LIMIT    = 5000;
    localparam int PHASES         = 8;
    localparam int PHASE_REQUESTS = 125;
    // In this phase neither side idles, so the block runs at full rate.
    localparam int STEADY_PHASE   = 3;

    typedef struct packed {
        logic                       motor;
        logic signed [SPEED_W-1:0]  target;
        logic signed [SPEED_W-1:0]  measured;
        logic signed [SPEED_W-1:0]  pid;
        logic        [TIME_W-1:0]   now;
    } speed_sample_t;

    // One line of the directed plan: either a register write or a request,
    // optionally with the drive that it must produce.
    typedef struct packed {
        logic                       is_write;
        mdc_reg_idx_t               reg_idx;
        logic        [PDATA_W-1:0]  reg_value;
        speed_sample_t              req;
        logic                       has_drive;
        logic signed [SPEED_W-1:0]  drive;
    } plan_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    wire  [PDATA_W-1:0] prdata;
    wire                pready;

    mdc_sample_if sample_ch ();
    mdc_result_if result_ch ();

    // The receiver's ready has a single driver so that it is known from time 0.
    logic sink_ready = 1'b0;
    assign result_ch.ready = sink_ready;

    motor_drive_compensation uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_ch),
        .result  (result_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Model state: register shadow plus the per-motor history.
    mdc_cfg_t                   shadow_cfg;
    logic signed [SPEED_W-1:0]  prior_cmd [MOTOR_COUNT];
    logic        [TIME_W-1:0]   kick_deadline [MOTOR_COUNT];

    // Predicted drive values, oldest first.
    logic signed [SPEED_W-1:0]  expected_drive [$];

    plan_row_t                  plan [$];

    // Random walk of the control loop: current target per motor and the clock.
    logic signed [SPEED_W-1:0]  walk_target [MOTOR_COUNT];
    logic        [TIME_W-1:0]   ms_clock;

    bit steady = 1'b0;
    int requests_sent   = 0;
    int directed_sent   = 0;
    int drives_checked  = 0;
    int mismatches      = 0;
    int reg_writes      = 0;
    int stall_cycles    = 0;

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // A level replaces the drive when the drive is weaker, keeping the target's
    // direction; a zero target counts as forward.
    function automatic longint raise_level(input longint drive,
                                           input logic signed [SPEED_W-1:0] target,
                                           input longint level);
        if (magnitude(drive) < level)
            return (target >= 0) ? level : -level;
        return drive;
    endfunction

    // Works out the drive for one request and advances the motor's history,
    // exactly as the block must when it consumes the request.
    function automatic logic signed [SPEED_W-1:0] compensate_drive(input speed_sample_t s);
        logic [GAIN_W-1:0]       gain;
        logic [BOOST_LVL_W-1:0]  kick_level;
        logic [BOOST_MS_W-1:0]   kick_ms;
        longint                  epsilon;
        longint                  abs_target;
        longint                  product;
        longint                  scaled;
        longint                  drive;
        longint                  limit;
        logic                    from_rest;
        logic                    reversed;
        logic                    same_dir;
        logic                    lagging;
        logic signed [SPEED_W-1:0] previous;

        gain       = (shadow_cfg.gain[s.motor] == '0) ? GAIN_ONE : shadow_cfg.gain[s.motor];
        kick_level = shadow_cfg.boost[s.motor][BOOST_LVL_W-1:0];
        kick_ms    = shadow_cfg.boost[s.motor][BOOST_W-1:BOOST_LVL_W];
        epsilon    = longint'(shadow_cfg.target_epsilon);
        abs_target = magnitude(longint'(s.target));

        // A target inside the stopping band forgets the motor's history.
        if (abs_target <= epsilon)
        begin
            prior_cmd[s.motor]     = '0;
            kick_deadline[s.motor] = '0;
            return '0;
        end

        // Starting from standstill or reversing opens a new kick window.
        previous    = prior_cmd[s.motor];
        from_rest   = magnitude(longint'(previous)) <= epsilon;
        reversed    = (previous < 0 && s.target > 0) || (previous > 0 && s.target < 0);
        if ((from_rest || reversed) && kick_level != '0 && kick_ms != '0)
            kick_deadline[s.motor] = s.now + TIME_W'(kick_ms);

        // Gain in Q4.12, halves rounded away from zero.
        product = longint'(s.pid) * longint'(gain);
        scaled  = (magnitude(product) + (longint'(1) << (GAIN_FRAC_BITS - 1)))
                  >> GAIN_FRAC_BITS;
        drive   = (product < 0) ? -scaled : scaled;

        same_dir = (drive == 0) || ((drive > 0) == (s.target > 0));
        lagging  = magnitude(longint'(s.measured)) + epsilon < abs_target;

        // The window compare is a plain unsigned compare, with no wrap handling.
        if (kick_level != '0 && s.now < kick_deadline[s.motor] && same_dir && lagging)
            drive = raise_level(drive, s.target, longint'(kick_level));
        if (shadow_cfg.min_drive[s.motor] != '0 && same_dir && lagging)
            drive = raise_level(drive, s.target, longint'(shadow_cfg.min_drive[s.motor]));

        prior_cmd[s.motor] = s.target;

        limit = longint'(shadow_cfg.drive_limit);
        if (drive > limit)
            drive = limit;
        if (drive < -limit)
            drive = -limit;
        return drive[SPEED_W-1:0];
    endfunction

    function automatic plan_row_t sample_row(input logic m, input int target, input int measured,
                                             input int pid, input logic [TIME_W-1:0] now,
                                             input bit known, input int drive);
        plan_row_t row;
        row              = '0;
        row.req.motor    = m;
        row.req.target   = SPEED_W'(target);
        row.req.measured = SPEED_W'(measured);
        row.req.pid      = SPEED_W'(pid);
        row.req.now      = now;
        row.has_drive    = known;
        row.drive        = SPEED_W'(drive);
        return row;
    endfunction

    function automatic plan_row_t reg_row(input mdc_reg_idx_t idx, input logic [PDATA_W-1:0] value);
        plan_row_t row;
        row           = '0;
        row.is_write  = 1'b1;
        row.reg_idx   = idx;
        row.reg_value = value;
        return row;
    endfunction

    function automatic bit idle_now();
        return !steady && ($urandom_range(99) < 21);
    endfunction

    // Next request of the simulated control loop. Most requests keep the
    // motor's target, some stop it, reverse it or jump somewhere new.
    function automatic speed_sample_t next_request();
        speed_sample_t s;
        int            pick;
        int            mag;

        s.motor = 1'($urandom_range(1));
        pick    = $urandom_range(99);
        if (pick < 10)
            walk_target[s.motor] = SPEED_W'(int'($urandom_range(10)) - 5);
        else if (pick < 22)
            walk_target[s.motor] = -walk_target[s.motor];
        else if (pick < 30)
            walk_target[s.motor] = SPEED_W'($urandom);
        else if (pick < 45)
        begin
            mag = $urandom_range(4000, 6);
            walk_target[s.motor] = SPEED_W'($urandom_range(1) ? mag : -mag);
        end
        s.target = walk_target[s.motor];

        // Measured speed usually trails the target somewhere between zero and
        // a little beyond it.
        if ($urandom_range(99) < 12)
            s.measured = SPEED_W'($urandom);
        else
            s.measured = SPEED_W'(int'(s.target) * int'($urandom_range(110)) / 100);

        mag = $urandom_range(3000);
        if (s.target < 0)
            mag = -mag;
        pick = $urandom_range(99);
        if (pick < 12)
            s.pid = SPEED_W'(-mag);
        else if (pick < 22)
            s.pid = SPEED_W'($urandom);
        else
            s.pid = SPEED_W'(mag);

        if ($urandom_range(99) < 3)
            ms_clock = $urandom;
        else
            ms_clock = ms_clock + TIME_W'($urandom_range(25));
        s.now = ms_clock;
        return s;
    endfunction

    // APB write: setup cycle, then access cycle; the register takes the value
    // at the edge where the access phase meets pready.
    task automatic write_register(input mdc_reg_idx_t idx, input logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TARGET_EPSILON: shadow_cfg.target_epsilon = value[LEVEL_W-1:0];
            REG_DRIVE_LIMIT:    shadow_cfg.drive_limit    = value[LEVEL_W-1:0];
            REG_GAIN_MOTOR0:    shadow_cfg.gain[0]        = value[GAIN_W-1:0];
            REG_GAIN_MOTOR1:    shadow_cfg.gain[1]        = value[GAIN_W-1:0];
            REG_MIN_MOTOR0:     shadow_cfg.min_drive[0]   = value[LEVEL_W-1:0];
            REG_MIN_MOTOR1:     shadow_cfg.min_drive[1]   = value[LEVEL_W-1:0];
            REG_BOOST_MOTOR0:   shadow_cfg.boost[0]       = value[BOOST_W-1:0];
            REG_BOOST_MOTOR1:   shadow_cfg.boost[1]       = value[BOOST_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Presents one request, with random idle cycles in front of it, and waits
    // for the edge that accepts it. Valid stays high on return so that the next
    // request can follow without a gap. The prediction is made right at the
    // accepting edge; a drive typed into the plan takes its place in the queue.
    task automatic send_request(input speed_sample_t s, input bit known,
                                input logic signed [SPEED_W-1:0] known_drive);
        logic signed [SPEED_W-1:0] predicted;
        while (idle_now())
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.motor_select   <= s.motor;
        sample_ch.speed_cmd      <= s.target;
        sample_ch.measured_speed <= s.measured;
        sample_ch.pid_drive      <= s.pid;
        sample_ch.now_ms         <= s.now;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        predicted = compensate_drive(s);
        expected_drive.push_back(known ? known_drive : predicted);
        requests_sent++;
    endtask

    // Stops sending and waits for every predicted drive to come back.
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // Register settings for the random bursts: the reset values, two sets of
    // extremes that together with them drive every register bit both ways, and then
    // random settings leaning towards values a real drive would use.
    task automatic configure_phase(input int phase);
        logic [PDATA_W-1:0] values [8];
        case (phase)
            0:
            begin
                values = '{32'(EPSILON_RESET), 32'(LIMIT_RESET), 32'(GAIN_ONE), 32'(GAIN_ONE),
                           32'd0, 32'd0, 32'd0, 32'd0};
            end
            1:
            begin
                values = '{32'd0, 32'd32767, 32'd0, 32'd65535,
                           32'd32767, 32'd1, 32'hFFFF_FFFF, 32'h0001_0001};
            end
            2:
            begin
                values = '{32'd32767, 32'd0, 32'd65535, 32'd0,
                           32'd0, 32'd32767, 32'd0, 32'hFFFF_FFFF};
            end
            default:
            begin
                values[REG_TARGET_EPSILON] = ($urandom_range(7) == 0) ?
                                             $urandom_range(32767) : $urandom_range(60);
                values[REG_DRIVE_LIMIT]    = $urandom_range(1) ? 32767 : $urandom_range(32767);
                for (int m = 0; m < 2; m++)
                begin
                    values[REG_GAIN_MOTOR0 + m] = ($urandom_range(3) == 0) ?
                                                  $urandom_range(65535) :
                                                  $urandom_range(12288, 2048);
                    values[REG_MIN_MOTOR0 + m]  = $urandom_range(1) ? 0 :
                                                  ($urandom_range(7) == 0) ?
                                                  $urandom_range(32767) : $urandom_range(4000);
                    values[REG_BOOST_MOTOR0 + m] = ($urandom_range(5) == 0) ? $urandom :
                                                   {16'($urandom_range(200)),
                                                    16'($urandom_range(20000))};
                end
            end
        endcase
        for (int i = 0; i < 8; i++)
            write_register(mdc_reg_idx_t'(i), values[i]);
    endtask

    // Receiver: ready drops in about a fifth of the cycles, except during the
    // steady phase.
    always @(posedge clk)
        sink_ready <= steady || ($urandom_range(99) >= 21);

    // Result checker: every accepted drive is matched against the oldest
    // prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_drive.size() == 0)
            begin
                $display("%0t: drive result %0d arrived with nothing expected",
                         $time, result_ch.drive_out);
                mismatches++;
            end
            else
            begin
                if (result_ch.drive_out !== expected_drive[0])
                begin
                    $display("%0t: drive_out mismatch, expected %0d, got %0d",
                             $time, expected_drive[0], result_ch.drive_out);
                    mismatches++;
                end
                void'(expected_drive.pop_front());
                drives_checked++;
            end
        end
    end

    // Hang detector: counts edges at which neither channel moves anything.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no traffic for %0d cycles", $time, STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        // Reset state of the model, matching the block after reset.
        shadow_cfg.target_epsilon = EPSILON_RESET;
        shadow_cfg.drive_limit    = LIMIT_RESET;
        shadow_cfg.gain           = {CFG_MOTORS{GAIN_ONE}};
        shadow_cfg.min_drive      = '0;
        shadow_cfg.boost          = '0;
        for (int m = 0; m < MOTOR_COUNT; m++)
        begin
            prior_cmd[m]     = '0;
            kick_deadline[m] = '0;
            walk_target[m]   = '0;
        end
        ms_clock = $urandom;

        sample_ch.valid          <= 1'b0;
        sample_ch.motor_select   <= 1'b0;
        sample_ch.speed_cmd      <= '0;
        sample_ch.measured_speed <= '0;
        sample_ch.pid_drive      <= '0;
        sample_ch.now_ms         <= '0;

        // Reset values: the stopping band edges, full-scale drive and the
        // symmetric saturation that turns -32768 into -32767.
        plan.push_back(sample_row(0, 0, 0, 1000, 32'd0, 1, 0));
        plan.push_back(sample_row(0, 5, 0, 32767, 32'd1, 1, 0));
        plan.push_back(sample_row(1, -5, 0, -32768, 32'd2, 1, 0));
        plan.push_back(sample_row(0, 6, 0, 32767, 32'd3, 1, 32767));
        plan.push_back(sample_row(1, -32768, 32767, -32768, 32'd4, 1, -32767));
        plan.push_back(sample_row(1, 32767, -32768, 0, 32'd5, 1, 0));
        // A zero gain reads as unity; the largest gain overflows into saturation.
        plan.push_back(reg_row(REG_GAIN_MOTOR0, 32'd0));
        plan.push_back(sample_row(0, 100, 0, -1234, 32'd6, 1, -1234));
        plan.push_back(reg_row(REG_GAIN_MOTOR0, 32'd65535));
        plan.push_back(sample_row(0, 100, 0, 1, 32'd7, 1, 16));
        plan.push_back(sample_row(0, 100, 0, -32768, 32'd8, 1, -32767));
        // Half gain: exact halves round away from zero in both directions.
        plan.push_back(reg_row(REG_GAIN_MOTOR1, 32'd2048));
        plan.push_back(sample_row(1, 100, 0, 3, 32'd9, 1, 2));
        plan.push_back(sample_row(1, 100, 0, -3, 32'd10, 1, -2));
        plan.push_back(reg_row(REG_DRIVE_LIMIT, 32'd1000));
        plan.push_back(sample_row(1, 100, 0, 5000, 32'd11, 1, 1000));
        // Minimum drive: applied only while lagging and pointing the target's
        // way; the lagging test sits right at its boundary in two rows.
        plan.push_back(reg_row(REG_DRIVE_LIMIT, 32'd32767));
        plan.push_back(reg_row(REG_GAIN_MOTOR0, 32'd4096));
        plan.push_back(reg_row(REG_GAIN_MOTOR1, 32'd4096));
        plan.push_back(reg_row(REG_MIN_MOTOR0, 32'd500));
        plan.push_back(sample_row(0, 1000, 0, 100, 32'd12, 1, 500));
        plan.push_back(sample_row(0, -1000, 0, -100, 32'd13, 1, -500));
        plan.push_back(sample_row(0, 1000, 996, 100, 32'd14, 1, 100));
        plan.push_back(sample_row(0, 1000, 994, 100, 32'd15, 1, 500));
        plan.push_back(sample_row(0, 1000, 0, -100, 32'd16, 1, -100));
        // Kick window of 50 ms at level 2000: opened from standstill, still
        // open one millisecond before the deadline, closed at it, reopened by
        // a reversal.
        plan.push_back(reg_row(REG_MIN_MOTOR0, 32'd0));
        plan.push_back(reg_row(REG_BOOST_MOTOR0, {16'd50, 16'd2000}));
        plan.push_back(sample_row(0, 0, 0, 0, 32'd1000, 1, 0));
        plan.push_back(sample_row(0, 300, 0, 10, 32'd1000, 1, 2000));
        plan.push_back(sample_row(0, 300, 0, 10, 32'd1049, 0, 0));
        plan.push_back(sample_row(0, 300, 0, 10, 32'd1050, 0, 0));
        plan.push_back(sample_row(0, -300, 0, -10, 32'd1060, 0, 0));
        // Levels above the limit, and a deadline that wraps past the top of
        // the clock and therefore never opens the window.
        plan.push_back(reg_row(REG_BOOST_MOTOR1, {16'd100, 16'd40000}));
        plan.push_back(reg_row(REG_MIN_MOTOR1, 32'd32767));
        plan.push_back(reg_row(REG_DRIVE_LIMIT, 32'd20000));
        plan.push_back(sample_row(1, 0, 0, 0, 32'hFFFF_FFF0, 1, 0));
        plan.push_back(sample_row(1, 500, 0, 10, 32'hFFFF_FFF0, 0, 0));
        plan.push_back(sample_row(1, -500, 0, 10, 32'hFFFF_FFF8, 0, 0));
        // With no stopping band a target of one already drives the motor.
        plan.push_back(reg_row(REG_TARGET_EPSILON, 32'd0));
        plan.push_back(sample_row(1, 1, 0, 0, 32'd0, 0, 0));

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register writes only go out once everything in flight is back.
        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                wait_drained();
                write_register(plan[i].reg_idx, plan[i].reg_value);
            end
            else
            begin
                send_request(plan[i].req, plan[i].has_drive, plan[i].drive);
            end
        end
        directed_sent = requests_sent;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            configure_phase(phase);
            steady = (phase == STEADY_PHASE);
            repeat (PHASE_REQUESTS)
                send_request(next_request(), 1'b0, '0);
        end
        wait_drained();
        mismatches += expected_drive.size();

        $display("Ran %0d requests (%0d from the directed plan) with %0d register writes",
                 requests_sent, directed_sent, reg_writes);
        $display("over %0d register settings; %0d drive results compared, %0d bad.",
                 PHASES, drives_checked, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
src/mdc_pkg.sv
src/mdc_sample_if.sv
src/mdc_result_if.sv
src/mdc_cfg_regs.sv
src/mdc_core.sv
src/motor_drive_compensation.sv
bench/motor_drive_compensation_tb.sv
